// ----- design/ssb_pkg.sv -----
// ----------------------------------------------------------------------------
// Scaled sprite blitter package
// Shared constants, word types, register and status codes, and the divider
// step used by the coordinate scaling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssb_pkg;

  localparam int unsigned MAX_SRC_PIXELS = 16384;
  localparam int unsigned SRC_AW         = $clog2(MAX_SRC_PIXELS);

  localparam int unsigned IDX_W    = 14;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned DIM_W    = 10;
  localparam int unsigned FB_W     = 11;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned PROD_W   = 2 * DIM_W;
  localparam int unsigned FB_PROD_W = 2 * FB_W;

  localparam int unsigned QUO_W      = DIM_W;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_DRAW = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TRANSPARENT = 2'd1,
    ST_CLIPPED     = 2'd2,
    ST_INVALID     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DEST_X      = 3'd2,
    REG_DEST_Y      = 3'd3,
    REG_DEST_WIDTH  = 3'd4,
    REG_DEST_HEIGHT = 3'd5,
    REG_FB_WIDTH    = 3'd6,
    REG_FB_HEIGHT   = 3'd7
  } reg_e;

  typedef struct packed {
    func_e              func;
    logic [IDX_W-1:0]   src_index;
    logic [COLOR_W-1:0] src_color;
    logic [DIM_W-1:0]   dest_col;
    logic [DIM_W-1:0]   dest_row;
  } in_word_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  fb_address;
    logic [COLOR_W-1:0] pixel_color;
    status_e            status;
  } out_word_t;

  typedef struct packed {
    logic [DIM_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

  typedef struct packed {
    func_e              func;
    logic [IDX_W-1:0]   src_index;
    logic               idx_ok;
    logic [COLOR_W-1:0] src_color;
    logic               size_bad;
    logic               rect_clip;
    logic               fb_clip;
    logic [FB_W-1:0]    fx;
    logic [FB_W-1:0]    fy;
  } side_t;

  function automatic div_stage_t div_step(input div_stage_t s, input logic [DIM_W-1:0] d);
    logic [DIM_W:0] t;
    logic           ge;
    div_stage_t     r;
    t     = {s.rem, s.num[QUO_W-1]};
    ge    = (t >= {1'b0, d});
    r.rem = ge ? DIM_W'(t - {1'b0, d}) : t[DIM_W-1:0];
    r.num = {s.num[QUO_W-2:0], 1'b0};
    r.quo = {s.quo[QUO_W-2:0], ge};
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/scaled_sprite_blitter.sv -----
// ----------------------------------------------------------------------------
// Scaled sprite blitter
// Nearest-neighbour sprite scaling with a colour key, from a palette-indexed
// source bitmap held in an internal store.
// ----------------------------------------------------------------------------
// The block takes one word per clock while in_stall_o is low and gives one
// result word per input word, in order. Each word passes an entry stage,
// two five-stage pipelined dividers working side by side, which resolve
// two quotient bits per stage, an index stage, the single-port source store
// read and the output register. Loads and draws use the store in the same
// pipeline stage, one access per cycle, so every draw sees all loads
// accepted before it. Store entries hold no value until written.
`default_nettype none

module scaled_sprite_blitter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ssb_pkg::CFG_AW-1:0]      paddr,
  input  wire logic [ssb_pkg::CFG_DW-1:0]      pwdata,
  output logic      [ssb_pkg::CFG_DW-1:0]      prdata,
  output logic                                 pready,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire ssb_pkg::in_word_t               in_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output ssb_pkg::out_word_t                   out_word_o
);

  localparam int unsigned ST_S1 = 0;
  localparam int unsigned ST_P  = ssb_pkg::DIV_STAGES + 1;
  localparam int unsigned ST_M  = ssb_pkg::DIV_STAGES + 2;
  localparam int unsigned ST_O  = ssb_pkg::DIV_STAGES + 3;
  localparam int unsigned NSTG  = ssb_pkg::DIV_STAGES + 4;

  logic [ssb_pkg::DIM_W-1:0]  src_width_q, src_height_q, dest_width_q, dest_height_q;
  logic [ssb_pkg::FB_W-1:0]   dest_x_q, dest_y_q, fb_width_q, fb_height_q;

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] en;

  ssb_pkg::side_t side_d;
  ssb_pkg::side_t side_q [ssb_pkg::DIV_STAGES+1];
  logic [ssb_pkg::PROD_W-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q, area;
  logic [ssb_pkg::FB_W:0]     fx_full, fy_full;

  logic [ssb_pkg::QUO_W-1:0]     sx, sy;
  logic [ssb_pkg::PROD_W-1:0]    pos_full;
  logic [ssb_pkg::FB_PROD_W-1:0] addr_full;
  ssb_pkg::side_t                p_side_q, m_side_q;
  logic [ssb_pkg::SRC_AW-1:0]    p_pos_q;
  logic [ssb_pkg::ADDR_W-1:0]    p_addr_q, m_addr_q;

  logic [ssb_pkg::COLOR_W-1:0] store [ssb_pkg::MAX_SRC_PIXELS];
  logic [ssb_pkg::COLOR_W-1:0] rdata_q;

  ssb_pkg::out_word_t out_d, out_q;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= '0;
      src_height_q  <= '0;
      dest_x_q      <= '0;
      dest_y_q      <= '0;
      dest_width_q  <= '0;
      dest_height_q <= '0;
      fb_width_q    <= ssb_pkg::FB_W'(320);
      fb_height_q   <= ssb_pkg::FB_W'(200);
    end else if (psel && penable && pwrite && pready) begin
      case (ssb_pkg::reg_e'(paddr[ssb_pkg::CFG_AW-1:2]))
        ssb_pkg::REG_SRC_WIDTH:   src_width_q   <= pwdata[ssb_pkg::DIM_W-1:0];
        ssb_pkg::REG_SRC_HEIGHT:  src_height_q  <= pwdata[ssb_pkg::DIM_W-1:0];
        ssb_pkg::REG_DEST_X:      dest_x_q      <= pwdata[ssb_pkg::FB_W-1:0];
        ssb_pkg::REG_DEST_Y:      dest_y_q      <= pwdata[ssb_pkg::FB_W-1:0];
        ssb_pkg::REG_DEST_WIDTH:  dest_width_q  <= pwdata[ssb_pkg::DIM_W-1:0];
        ssb_pkg::REG_DEST_HEIGHT: dest_height_q <= pwdata[ssb_pkg::DIM_W-1:0];
        ssb_pkg::REG_FB_WIDTH:    fb_width_q    <= pwdata[ssb_pkg::FB_W-1:0];
        ssb_pkg::REG_FB_HEIGHT:   fb_height_q   <= pwdata[ssb_pkg::FB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ssb_pkg::reg_e'(paddr[ssb_pkg::CFG_AW-1:2]))
      ssb_pkg::REG_SRC_WIDTH:   prdata = ssb_pkg::CFG_DW'(src_width_q);
      ssb_pkg::REG_SRC_HEIGHT:  prdata = ssb_pkg::CFG_DW'(src_height_q);
      ssb_pkg::REG_DEST_X:      prdata = ssb_pkg::CFG_DW'(dest_x_q);
      ssb_pkg::REG_DEST_Y:      prdata = ssb_pkg::CFG_DW'(dest_y_q);
      ssb_pkg::REG_DEST_WIDTH:  prdata = ssb_pkg::CFG_DW'(dest_width_q);
      ssb_pkg::REG_DEST_HEIGHT: prdata = ssb_pkg::CFG_DW'(dest_height_q);
      ssb_pkg::REG_FB_WIDTH:    prdata = ssb_pkg::CFG_DW'(fb_width_q);
      ssb_pkg::REG_FB_HEIGHT:   prdata = ssb_pkg::CFG_DW'(fb_height_q);
      default:                  prdata = '0;
    endcase
  end

  // Pipeline flow: a stage loads when it is empty or its successor moves on.
  always_comb begin
    en[NSTG-1] = !valid_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[ST_S1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Entry stage: products, size checks and framebuffer position.
  always_comb begin
    prod_x_d = ssb_pkg::PROD_W'(in_word_i.dest_col) * ssb_pkg::PROD_W'(src_width_q);
    prod_y_d = ssb_pkg::PROD_W'(in_word_i.dest_row) * ssb_pkg::PROD_W'(src_height_q);
    area     = ssb_pkg::PROD_W'(src_width_q) * ssb_pkg::PROD_W'(src_height_q);
    fx_full  = {dest_x_q[ssb_pkg::FB_W-1], dest_x_q} +
               (ssb_pkg::FB_W + 1)'(in_word_i.dest_col);
    fy_full  = {dest_y_q[ssb_pkg::FB_W-1], dest_y_q} +
               (ssb_pkg::FB_W + 1)'(in_word_i.dest_row);

    side_d.func      = in_word_i.func;
    side_d.src_index = in_word_i.src_index;
    side_d.idx_ok    = (32'(in_word_i.src_index) < ssb_pkg::MAX_SRC_PIXELS);
    side_d.src_color = in_word_i.src_color;
    side_d.size_bad  = (src_width_q == '0) || (src_height_q == '0) ||
                       (dest_width_q == '0) || (dest_height_q == '0) ||
                       (32'(area) > ssb_pkg::MAX_SRC_PIXELS);
    side_d.rect_clip = (in_word_i.dest_col >= dest_width_q) ||
                       (in_word_i.dest_row >= dest_height_q);
    side_d.fb_clip   = fx_full[ssb_pkg::FB_W] || fy_full[ssb_pkg::FB_W] ||
                       (fx_full[ssb_pkg::FB_W-1:0] >= fb_width_q) ||
                       (fy_full[ssb_pkg::FB_W-1:0] >= fb_height_q);
    side_d.fx        = fx_full[ssb_pkg::FB_W-1:0];
    side_d.fy        = fy_full[ssb_pkg::FB_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_S1]) begin
      side_q[0] <= side_d;
      prod_x_q  <= prod_x_d;
      prod_y_q  <= prod_y_d;
    end
    for (int k = 1; k <= ssb_pkg::DIV_STAGES; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  ssb_div u_div_x (
    .clk_i      (clk_i),
    .en_i       (en[ssb_pkg::DIV_STAGES:1]),
    .dividend_i (prod_x_q),
    .divisor_i  (dest_width_q),
    .quot_o     (sx)
  );

  ssb_div u_div_y (
    .clk_i      (clk_i),
    .en_i       (en[ssb_pkg::DIV_STAGES:1]),
    .dividend_i (prod_y_q),
    .divisor_i  (dest_height_q),
    .quot_o     (sy)
  );

  // Index stage: store position and framebuffer offset.
  always_comb begin
    pos_full  = ssb_pkg::PROD_W'(sy) * ssb_pkg::PROD_W'(src_width_q) +
                ssb_pkg::PROD_W'(sx);
    addr_full = ssb_pkg::FB_PROD_W'(side_q[ssb_pkg::DIV_STAGES].fy) *
                ssb_pkg::FB_PROD_W'(fb_width_q) +
                ssb_pkg::FB_PROD_W'(side_q[ssb_pkg::DIV_STAGES].fx);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_P]) begin
      p_side_q <= side_q[ssb_pkg::DIV_STAGES];
      p_pos_q  <= pos_full[ssb_pkg::SRC_AW-1:0];
      p_addr_q <= addr_full[ssb_pkg::ADDR_W-1:0];
    end
  end

  // Source store: a load writes and a draw reads, one access per cycle.
  always_ff @(posedge clk_i) begin
    if (en[ST_M] && valid_q[ST_P]) begin
      if (p_side_q.func == ssb_pkg::FUNC_LOAD) begin
        if (p_side_q.idx_ok) begin
          store[ssb_pkg::SRC_AW'(p_side_q.src_index)] <= p_side_q.src_color;
        end
      end else begin
        rdata_q <= store[p_pos_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_M]) begin
      m_side_q <= p_side_q;
      m_addr_q <= p_addr_q;
    end
  end

  // Result stage.
  always_comb begin
    out_d.write_enable = 1'b0;
    out_d.fb_address   = '0;
    out_d.pixel_color  = '0;
    out_d.status       = ssb_pkg::ST_OK;
    if (m_side_q.func == ssb_pkg::FUNC_DRAW) begin
      if (m_side_q.size_bad) begin
        out_d.status = ssb_pkg::ST_INVALID;
      end else if (m_side_q.rect_clip) begin
        out_d.status = ssb_pkg::ST_CLIPPED;
      end else if (rdata_q == '0) begin
        out_d.status = ssb_pkg::ST_TRANSPARENT;
      end else if (m_side_q.fb_clip) begin
        out_d.status = ssb_pkg::ST_CLIPPED;
      end else begin
        out_d.write_enable = 1'b1;
        out_d.fb_address   = m_addr_q;
        out_d.pixel_color  = rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_O]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[ST_O];
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ----- design/ssb_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined scaling divider
// Restoring division of a 20-bit product by a 10-bit divisor, giving a 10-bit
// quotient, with two quotient bits resolved in each stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_div (
  input  wire logic                                clk_i,
  input  wire logic [ssb_pkg::DIV_STAGES-1:0]      en_i,
  input  wire logic [ssb_pkg::PROD_W-1:0]          dividend_i,
  input  wire logic [ssb_pkg::DIM_W-1:0]           divisor_i,
  output logic      [ssb_pkg::QUO_W-1:0]           quot_o
);

  ssb_pkg::div_stage_t stage_q [ssb_pkg::DIV_STAGES];
  ssb_pkg::div_stage_t stage_d [ssb_pkg::DIV_STAGES];
  ssb_pkg::div_stage_t first;

  // The quotient is known to fit in QUO_W bits, so the upper half of the
  // dividend is already a valid partial remainder.
  assign first.rem = dividend_i[ssb_pkg::PROD_W-1:ssb_pkg::QUO_W];
  assign first.num = dividend_i[ssb_pkg::QUO_W-1:0];
  assign first.quo = '0;

  for (genvar k = 0; k < ssb_pkg::DIV_STAGES; k++) begin : g_stage
    always_comb begin
      ssb_pkg::div_stage_t s;
      s = (k == 0) ? first : stage_q[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < ssb_pkg::DIV_STEPS; j++) begin
        s = ssb_pkg::div_step(s, divisor_i);
      end
      stage_d[k] = s;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign quot_o = stage_q[ssb_pkg::DIV_STAGES-1].quo;

endmodule

`default_nettype wire

// ----- design/ssb_chk.sv -----
// ----------------------------------------------------------------------------
// Scaled sprite blitter port checker
// Watches the top level's result port and checks the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_stall_i,
  input wire ssb_pkg::out_word_t out_word_i
);

  a_write_is_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.write_enable |-> out_word_i.status == ssb_pkg::ST_OK)
    else $error("Framebuffer write reported with a non-zero status.");

  a_write_not_keyed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.write_enable |-> out_word_i.pixel_color != '0)
    else $error("Framebuffer write of the transparent colour.");

  a_no_write_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.write_enable |->
      out_word_i.fb_address == '0 && out_word_i.pixel_color == '0)
    else $error("Suppressed write carries a non-zero address or colour.");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i))
    else $error("Stalled result word changed or was dropped.");

endmodule

bind scaled_sprite_blitter ssb_chk u_ssb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);

`default_nettype wire

// ----- test/scaled_sprite_blitter_tb.sv -----
// ----------------------------------------------------------------------------
// Scaled sprite blitter testbench
// Loads sprite pixels and draws destination pixels through the word stream,
// predicts every result word from an internal sprite store and register copy,
// and checks each result field by field while both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scaled_sprite_blitter_tb;

  localparam int HOLD_CYCLES = 200;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ssb_pkg::CFG_AW-1:0] paddr;
  logic [ssb_pkg::CFG_DW-1:0] pwdata;
  logic [ssb_pkg::CFG_DW-1:0] prdata;
  logic                       pready;
  logic                       in_valid_i;
  logic                       in_stall_o;
  ssb_pkg::in_word_t          in_word_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  ssb_pkg::out_word_t         out_word_o;

  scaled_sprite_blitter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Copy of the sprite store and registers, as the block should hold them.
  logic [ssb_pkg::COLOR_W-1:0] sprite_mem [ssb_pkg::MAX_SRC_PIXELS];
  bit                          sprite_loaded [ssb_pkg::MAX_SRC_PIXELS];
  int cfg_src_w  = 0;
  int cfg_src_h  = 0;
  int cfg_dest_x = 0;
  int cfg_dest_y = 0;
  int cfg_dest_w = 0;
  int cfg_dest_h = 0;
  int cfg_fb_w   = 320;
  int cfg_fb_h   = 200;

  ssb_pkg::out_word_t expected_px [$];
  int                 mismatches    = 0;
  bit                 send_idle     = 1'b1;
  bit                 recv_idle     = 1'b1;
  int                 hold_requests = 0;

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic bit size_invalid();
    return cfg_src_w == 0 || cfg_src_h == 0 || cfg_dest_w == 0 || cfg_dest_h == 0 ||
           cfg_src_w * cfg_src_h > int'(ssb_pkg::MAX_SRC_PIXELS);
  endfunction

  // Store position that a draw fetches, or -1 where the draw is invalid or outside the destination rectangle.
  function automatic int sprite_pos(int col, int row);
    if (size_invalid() || col >= cfg_dest_w || row >= cfg_dest_h) return -1;
    return (row * cfg_src_h / cfg_dest_h) * cfg_src_w + col * cfg_src_w / cfg_dest_w;
  endfunction

  function automatic ssb_pkg::out_word_t blit_pixel(ssb_pkg::in_word_t w);
    ssb_pkg::out_word_t          r;
    int                          pos;
    int                          fx;
    int                          fy;
    logic [ssb_pkg::COLOR_W-1:0] c;
    r = '0;
    r.status = ssb_pkg::ST_OK;
    if (w.func == ssb_pkg::FUNC_LOAD) begin
      sprite_mem[w.src_index] = w.src_color;
      sprite_loaded[w.src_index] = 1'b1;
      return r;
    end
    if (size_invalid()) begin
      r.status = ssb_pkg::ST_INVALID;
      return r;
    end
    pos = sprite_pos(int'(w.dest_col), int'(w.dest_row));
    if (pos < 0) begin
      r.status = ssb_pkg::ST_CLIPPED;
      return r;
    end
    c = sprite_mem[pos];
    if (c == '0) begin
      r.status = ssb_pkg::ST_TRANSPARENT;
      return r;
    end
    fx = cfg_dest_x + int'(w.dest_col);
    fy = cfg_dest_y + int'(w.dest_row);
    if (fx < 0 || fy < 0 || fx >= cfg_fb_w || fy >= cfg_fb_h) begin
      r.status = ssb_pkg::ST_CLIPPED;
      return r;
    end
    r.write_enable = 1'b1;
    r.fb_address   = ssb_pkg::ADDR_W'(fy * cfg_fb_w + fx);
    r.pixel_color  = c;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ssb_pkg::out_word_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_px.size() == 0) begin
        $error("result word with none expected: %h", out_word_o);
        mismatches++;
      end else begin
        want = expected_px.pop_front();
        check_field("write_enable", 32'(want.write_enable), 32'(out_word_o.write_enable));
        check_field("fb_address", 32'(want.fb_address), 32'(out_word_o.fb_address));
        check_field("pixel_color", 32'(want.pixel_color), 32'(out_word_o.pixel_color));
        check_field("status", 32'(want.status), 32'(out_word_o.status));
      end
    end
  end

  // Receiver: random stalls, and a long hold-off whenever one is requested.
  initial begin : recv_stall
    int          holds_served;
    int unsigned run_len;
    holds_served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        run_len = recv_idle ? idle_len() : 0;
        if (run_len != 0) begin
          out_stall_i <= 1'b1;
          repeat (run_len) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(ssb_pkg::in_word_t w);
    int unsigned gap;
    gap = send_idle ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    expected_px.push_back(blit_pixel(w));
  endtask

  task automatic load_px(int idx, int colour);
    ssb_pkg::in_word_t w;
    w.func      = ssb_pkg::FUNC_LOAD;
    w.src_index = ssb_pkg::IDX_W'(idx);
    w.src_color = ssb_pkg::COLOR_W'(colour);
    w.dest_col  = ssb_pkg::DIM_W'($urandom);
    w.dest_row  = ssb_pkg::DIM_W'($urandom);
    send_word(w);
  endtask

  task automatic draw_px(int col, int row);
    ssb_pkg::in_word_t w;
    w.func      = ssb_pkg::FUNC_DRAW;
    w.src_index = ssb_pkg::IDX_W'($urandom);
    w.src_color = ssb_pkg::COLOR_W'($urandom);
    w.dest_col  = ssb_pkg::DIM_W'(col);
    w.dest_row  = ssb_pkg::DIM_W'(row);
    send_word(w);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(ssb_pkg::reg_e r, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= 32'(value) & 32'h7FF;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      ssb_pkg::REG_SRC_WIDTH:   cfg_src_w  = value & 'h3FF;
      ssb_pkg::REG_SRC_HEIGHT:  cfg_src_h  = value & 'h3FF;
      ssb_pkg::REG_DEST_X:      cfg_dest_x = int'($signed(11'(value)));
      ssb_pkg::REG_DEST_Y:      cfg_dest_y = int'($signed(11'(value)));
      ssb_pkg::REG_DEST_WIDTH:  cfg_dest_w = value & 'h3FF;
      ssb_pkg::REG_DEST_HEIGHT: cfg_dest_h = value & 'h3FF;
      ssb_pkg::REG_FB_WIDTH:    cfg_fb_w   = value & 'h7FF;
      ssb_pkg::REG_FB_HEIGHT:   cfg_fb_h   = value & 'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_blit(int sw, int sh, int dx, int dy, int dw, int dh, int fbw, int fbh);
    drain_results();
    write_reg(ssb_pkg::REG_SRC_WIDTH, sw);
    write_reg(ssb_pkg::REG_SRC_HEIGHT, sh);
    write_reg(ssb_pkg::REG_DEST_X, dx);
    write_reg(ssb_pkg::REG_DEST_Y, dy);
    write_reg(ssb_pkg::REG_DEST_WIDTH, dw);
    write_reg(ssb_pkg::REG_DEST_HEIGHT, dh);
    write_reg(ssb_pkg::REG_FB_WIDTH, fbw);
    write_reg(ssb_pkg::REG_FB_HEIGHT, fbh);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic int rand_colour();
    return ($urandom_range(0, 99) < 20) ? 0 : int'($urandom_range(1, 255));
  endfunction

  function automatic int rand_dim(int common_max);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return 0;
    if (p < 70) return $urandom_range(1, common_max);
    if (p < 90) return $urandom_range(common_max + 1, 64);
    return $urandom_range(65, 1023);
  endfunction

  function automatic int rand_fb();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return 0;
    if (p < 45) return $urandom_range(1, 64);
    if (p < 80) return $urandom_range(65, 1024);
    return $urandom_range(1025, 2047);
  endfunction

  function automatic int rand_offset();
    if ($urandom_range(0, 99) < 60) return int'($urandom_range(0, 48)) - 24;
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic int rand_coord(int extent);
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, (extent < 1023) ? extent + 1 : 1023);
    return $urandom_range(0, 1023);
  endfunction

  task automatic test_reset_state();
    draw_px(0, 0);
    load_px(16383, 8'hFF);
    load_px(0, 8'h00);
  endtask

  task automatic test_unscaled_blit();
    int i;
    int colours [8] = '{8'h01, 8'h00, 8'h80, 8'hFF, 8'h7E, 8'h55, 8'hAA, 8'h10};
    set_blit(4, 2, 2, 1, 4, 2, 320, 200);
    for (i = 0; i < 8; i++) load_px(i, colours[i]);
    draw_px(0, 0);
    draw_px(1, 0);
    draw_px(3, 1);
    draw_px(4, 0);
    draw_px(0, 2);
    draw_px(1023, 1023);
  endtask

  task automatic test_scaling_and_clipping();
    set_blit(4, 2, -1, -1, 8, 4, 320, 200);
    draw_px(0, 0);
    draw_px(2, 0);
    draw_px(7, 3);
    set_blit(4, 2, 1023, 1023, 1023, 1023, 2047, 2047);
    draw_px(1022, 1022);
    draw_px(1023, 0);
    set_blit(4, 2, -1024, 0, 4, 2, 1024, 1024);
    draw_px(3, 1);
    set_blit(4, 2, 0, 0, 4, 2, 0, 0);
    draw_px(0, 0);
  endtask

  task automatic test_invalid_size();
    set_blit(1023, 17, 0, 0, 4, 2, 320, 200);
    draw_px(0, 0);
    set_blit(128, 128, 0, 0, 1, 1, 320, 200);
    draw_px(0, 0);
    set_blit(4, 2, 5, 5, 0, 2, 320, 200);
    draw_px(0, 0);
  endtask

  task automatic test_backpressure();
    int i;
    set_blit(6, 5, 3, 2, 12, 10, 64, 48);
    for (i = 0; i < 30; i++) load_px(i, rand_colour());
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_requests++;
    for (i = 0; i < 80; i++) draw_px($urandom_range(0, 12), $urandom_range(0, 10));
    send_idle = 1'b1;
    recv_idle = 1'b1;
    drain_results();
  endtask

  task automatic test_random_phase(int n_items, bit with_pause);
    int i;
    int area;
    int col;
    int row;
    int pos;
    int tries;
    bit done;
    set_blit(rand_dim(8), rand_dim(8), rand_offset(), rand_offset(),
             rand_dim(24), rand_dim(24), rand_fb(), rand_fb());
    area = cfg_src_w * cfg_src_h;
    for (i = 0; i < area && i < 32; i++) load_px(i, rand_colour());
    for (i = 0; i < n_items; i++) begin
      if (with_pause && i == n_items / 2) drain_results();
      done = 1'b0;
      if ($urandom_range(0, 99) >= 20) begin
        for (tries = 0; tries < 16 && !done; tries++) begin
          col  = rand_coord(cfg_dest_w);
          row  = rand_coord(cfg_dest_h);
          pos  = sprite_pos(col, row);
          done = (pos < 0) || sprite_loaded[pos];
        end
      end
      if (done) begin
        draw_px(col, row);
      end else if (area > 0 && $urandom_range(0, 99) < 70) begin
        load_px($urandom_range(0, ((area < 16384) ? area : 16384) - 1), rand_colour());
      end else begin
        load_px($urandom_range(0, 16383), rand_colour());
      end
    end
  endtask

  initial begin : stimulus
    int k;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    rst_ni     <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_unscaled_blit();
    test_scaling_and_clipping();
    test_invalid_size();
    test_backpressure();
    for (k = 0; k < 8; k++) begin
      send_idle = (k % 3 != 0);
      recv_idle = (k % 4 != 1);
      test_random_phase(110, k % 2 == 0);
    end
    drain_results();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
design/ssb_pkg.sv
design/ssb_div.sv
design/scaled_sprite_blitter.sv
design/ssb_chk.sv
test/scaled_sprite_blitter_tb.sv
